@@ hw/rtl/cfbf_pkg.sv @@
// ----------------------------------------------------------------------------
// CRC framed byte FIFO package
// Shared sizes, opcode and state types, command struct and the CRC-8 step.
// ----------------------------------------------------------------------------
package cfbf_pkg;

    // Number of slots in the byte store; one slot is always kept free.
    localparam int unsigned DEPTH  = 64;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;
    localparam logic [7:0] CRC_INIT = 8'h00;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_MSG  = 2'd1,
        OP_CRC  = 2'd2,
        OP_POP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_SEND
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } t_dp_cmd;

    // Advances a pointer by one slot with wrap at the store depth.
    function automatic t_addr next_slot(input t_addr p);
        t_addr n;
        if (p == t_addr'(DEPTH - 1)) begin
            n = '0;
        end else begin
            n = p + t_addr'(1);
        end
        return n;
    endfunction

    // Folds one byte into a CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/cfbf_ifs.sv @@
// ----------------------------------------------------------------------------
// CRC framed byte FIFO channel interfaces
// Valid/ready channels for command items in and result items out.
// ----------------------------------------------------------------------------
interface cfbf_in_if;
    logic              valid;
    logic              ready;
    cfbf_pkg::t_opcode opcode;
    logic [7:0]        byte_value;

    modport source (output valid, output opcode, output byte_value, input ready);
    modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface cfbf_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic [7:0] popped_byte;
    logic       is_full;
    logic       is_empty;

    modport source (output valid, output accepted, output popped_byte,
                    output is_full, output is_empty, input ready);
    modport sink   (input valid, input accepted, input popped_byte,
                    input is_full, input is_empty, output ready);
endinterface

@@ hw/rtl/crc_framed_byte_fifo.sv @@
// ----------------------------------------------------------------------------
// CRC framed byte FIFO
// Byte ring FIFO for log messages with a CRC-8 (poly 0x07) message framer.
// ----------------------------------------------------------------------------
// Each input item carries an opcode: a plain push stores a byte, a message
// push stores a byte and folds it into a running CRC-8 (polynomial 0x07,
// initial value zero, MSB first), an end-of-message item stores the running
// CRC and clears it, and a pop returns the oldest byte. The store holds
// DEPTH-1 bytes at most, since one slot is always left free to tell full from
// empty. A push into a full FIFO or a pop from an empty one is refused and
// reported with accepted low; a refused message push still updates the CRC
// and a refused end-of-message item still clears it. Every item yields exactly
// one result item with the accepted flag, the popped byte (zero unless a pop
// succeeded) and the full and empty flags after the item. Items are handled
// one at a time: after an item is accepted, the controller steps through the
// execute and result load steps and then holds the result valid until it is
// taken, and the next item can be accepted in the cycle after the result is
// taken. This sequence comes from the execute step, the registered read port
// of the byte store and the single result register. The store needs no
// clearing after reset.
module crc_framed_byte_fifo (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfbf_in_if.sink   i_in,
    cfbf_out_if.source o_out
);
    import cfbf_pkg::*;

    t_dp_cmd cmd;

    // The controller owns the handshakes and steps the datapath.
    cfbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the store, the pointers, the CRC and the result.
    cfbf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_in.opcode),
        .i_byte_value  (i_in.byte_value),
        .o_accepted    (o_out.accepted),
        .o_popped_byte (o_out.popped_byte),
        .o_is_full     (o_out.is_full),
        .o_is_empty    (o_out.is_empty)
    );

endmodule

@@ hw/rtl/cfbf_ctrl.sv @@
// ----------------------------------------------------------------------------
// CRC framed byte FIFO controller
// Sequences one item through capture, execute, result load and delivery.
// ----------------------------------------------------------------------------
module cfbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output cfbf_pkg::t_dp_cmd o_cmd
);
    import cfbf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: n_state = ST_LOAD;
            ST_LOAD: n_state = ST_SEND;
            ST_SEND: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_EXEC: o_cmd.execute = 1'b1;
            ST_LOAD: o_cmd.load = 1'b1;
            ST_SEND: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

@@ hw/rtl/cfbf_datapath.sv @@
// ----------------------------------------------------------------------------
// CRC framed byte FIFO datapath
// Byte store, pointers, running CRC-8 and the result register.
// ----------------------------------------------------------------------------
module cfbf_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfbf_pkg::t_dp_cmd i_cmd,
    input  cfbf_pkg::t_opcode i_opcode,
    input  logic [7:0]        i_byte_value,
    output logic              o_accepted,
    output logic [7:0]        o_popped_byte,
    output logic              o_is_full,
    output logic              o_is_empty
);
    import cfbf_pkg::*;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    t_addr      r_wr_ptr;
    t_addr      r_rd_ptr;
    logic [7:0] r_crc;

    t_opcode    r_opcode;
    logic [7:0] r_byte;
    logic       r_ok;
    logic       r_pop_ok;

    logic       r_accepted;
    logic [7:0] r_popped_byte;
    logic       r_is_full;
    logic       r_is_empty;

    logic       full;
    logic       empty;
    logic       is_push;
    logic       do_write;
    logic       do_pop;
    logic [7:0] wr_data;

    assign full     = (next_slot(r_wr_ptr) == r_rd_ptr);
    assign empty    = (r_wr_ptr == r_rd_ptr);
    assign is_push  = (r_opcode != OP_POP);
    assign do_write = i_cmd.execute && is_push && !full;
    assign do_pop   = i_cmd.execute && !is_push && !empty;
    assign wr_data  = (r_opcode == OP_CRC) ? r_crc : r_byte;

    // Item capture; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_opcode <= i_opcode;
            r_byte   <= i_byte_value;
        end
    end

    // Store with one write port and a registered read port.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_wr_ptr] <= wr_data;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    // Pointers and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_crc    <= CRC_INIT;
        end else if (i_cmd.execute) begin
            if (do_write) begin
                r_wr_ptr <= next_slot(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= next_slot(r_rd_ptr);
            end
            // The CRC is folded or cleared even when the push is refused.
            case (r_opcode)
                OP_MSG:  r_crc <= crc_fold(r_crc, r_byte);
                OP_CRC:  r_crc <= CRC_INIT;
                default: r_crc <= r_crc;
            endcase
        end
    end

    // Outcome of the execute step, used when the result is loaded.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_ok     <= do_write || do_pop;
            r_pop_ok <= do_pop;
        end
    end

    // Result register; flags reflect the pointers after the update.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_accepted    <= r_ok;
            r_popped_byte <= r_pop_ok ? r_rd_data : 8'h00;
            r_is_full     <= full;
            r_is_empty    <= empty;
        end
    end

    assign o_accepted    = r_accepted;
    assign o_popped_byte = r_popped_byte;
    assign o_is_full     = r_is_full;
    assign o_is_empty    = r_is_empty;

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// CRC framed byte FIFO testbench
// Drives opcode items through the valid/ready channels and checks each
// result item against a cycle-free shadow of the FIFO and its CRC-8 framer.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfbf_pkg::*;

    // Number of generated items after the directed opening.
    localparam int unsigned RANDOM_ITEMS = 1500;
    // Cycles without any handshake before the run is declared hung. The block
    // sees one item at a time, so the longest quiet stretch is the forced
    // receiver hold plus a sender gap plus the block's own item handling.
    localparam int unsigned STALL_LIMIT  = 4000;
    // Length of each forced receiver hold.
    localparam int unsigned HOLD_CYCLES  = 250;
    // Cycles to wait after the last result so that a stray extra item shows.
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct {
        t_opcode    op;
        logic [7:0] value;
    } t_fifo_cmd;

    typedef struct {
        logic       accepted;
        logic [7:0] popped_byte;
        logic       is_full;
        logic       is_empty;
    } t_fifo_status;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cfbf_in_if  cmd_if ();
    cfbf_out_if res_if ();

    crc_framed_byte_fifo DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    always #10ns i_clk = ~i_clk;

    // Items still to be offered, and result items still owed by the block.
    t_fifo_cmd    cmd_backlog [$];
    t_fifo_status status_due  [$];

    // Shadow of the FIFO: byte slots, the two pointers and the message CRC.
    logic [7:0] shadow_bytes [DEPTH];
    t_addr      shadow_wr;
    t_addr      shadow_rd;
    logic [7:0] shadow_crc;

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;

    // Set at a rising edge when the offered item was taken, so the driver
    // knows at the following falling edge that it may move on.
    logic cmd_taken = 1'b0;

    // Sender burst shaping.
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;

    // Receiver stall shaping, including the long holds that back the block up.
    int unsigned stall_mode  = 0;
    int unsigned phase_left  = 0;
    int unsigned stall_tick  = 0;
    int unsigned hold_left   = 0;
    int unsigned hold_at [$] = '{300, 1000};

    // Pointer advance with wrap at the store depth.
    function automatic t_addr slot_after(input t_addr p);
        return t_addr'((int'(p) + 1) % DEPTH);
    endfunction

    // Bit-serial CRC-8 register: each data bit, MSB first, is compared with
    // the register's top bit and the polynomial is applied on a difference.
    function automatic logic [7:0] crc8_shift_in(input logic [7:0] crc,
                                                 input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    // Stores one byte unless the FIFO is full; returns whether it was stored.
    function automatic logic shadow_store(input logic [7:0] b);
        if (slot_after(shadow_wr) == shadow_rd) begin
            return 1'b0;
        end
        shadow_bytes[shadow_wr] = b;
        shadow_wr = slot_after(shadow_wr);
        return 1'b1;
    endfunction

    // Applies one accepted item to the shadow and returns the result item the
    // block owes for it.
    function automatic t_fifo_status fifo_step(input t_fifo_cmd cmd);
        t_fifo_status st;
        st.accepted    = 1'b0;
        st.popped_byte = 8'h00;
        case (cmd.op)
            OP_PUSH: begin
                st.accepted = shadow_store(cmd.value);
            end
            OP_MSG: begin
                // The CRC takes the byte even when the store refuses it.
                shadow_crc  = crc8_shift_in(shadow_crc, cmd.value);
                st.accepted = shadow_store(cmd.value);
            end
            OP_CRC: begin
                // End of message clears the CRC even when the store is full.
                st.accepted = shadow_store(shadow_crc);
                shadow_crc  = CRC_INIT;
            end
            default: begin
                if (shadow_wr != shadow_rd) begin
                    st.popped_byte = shadow_bytes[shadow_rd];
                    shadow_rd      = slot_after(shadow_rd);
                    st.accepted    = 1'b1;
                end
            end
        endcase
        st.is_full  = (slot_after(shadow_wr) == shadow_rd);
        st.is_empty = (shadow_wr == shadow_rd);
        return st;
    endfunction

    task automatic add_cmd(input t_opcode op, input logic [7:0] value);
        t_fifo_cmd c;
        c.op    = op;
        c.value = value;
        cmd_backlog.push_back(c);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
            mismatches++;
        end
    endtask

    // Opening items: pop and end-of-message on an empty FIFO, both byte
    // extremes as plain and message pushes, a framed message whose CRC goes
    // into the store, and pops that drain it past empty. The byte field of
    // pops and end-of-message items carries junk that must be ignored.
    task automatic plan_directed();
        add_cmd(OP_POP,  8'hFF);
        add_cmd(OP_CRC,  8'h00);
        add_cmd(OP_PUSH, 8'h00);
        add_cmd(OP_PUSH, 8'hFF);
        add_cmd(OP_MSG,  8'h00);
        add_cmd(OP_MSG,  8'hFF);
        add_cmd(OP_MSG,  8'h80);
        add_cmd(OP_MSG,  8'h01);
        add_cmd(OP_CRC,  8'hFF);
        for (int i = 0; i < 9; i++) begin
            add_cmd(OP_POP, (i % 2 == 0) ? 8'h00 : 8'hFF);
        end
        add_cmd(OP_MSG,  8'h55);
        add_cmd(OP_PUSH, 8'hAA);
        add_cmd(OP_CRC,  8'h5A);
        for (int i = 0; i < 4; i++) begin
            add_cmd(OP_POP, 8'hA5);
        end
    endtask

    // Generated traffic. It opens with a message longer than the store, so
    // message bytes are refused while still entering the CRC and the closing
    // end-of-message is refused while still clearing it, followed by pops
    // past empty. After that come segments that lean toward filling, toward
    // draining, or neither, so both full and empty are reached again and
    // again. Pushes are mostly framed messages of random length; a few are
    // plain bytes or a lone end-of-message, and rare noise segments send
    // arbitrary opcodes that break messages apart.
    task automatic plan_random_traffic();
        int unsigned made;
        int unsigned mode;
        int unsigned seg_left;
        int unsigned msg_left;
        int unsigned roll;
        logic        want_push;
        made     = 0;
        mode     = 0;
        seg_left = 0;
        msg_left = 0;
        repeat (DEPTH + 2) begin
            add_cmd(OP_MSG, $urandom_range(0, 255));
            made++;
        end
        add_cmd(OP_CRC, $urandom_range(0, 255));
        made++;
        repeat (DEPTH + 2) begin
            add_cmd(OP_POP, $urandom_range(0, 255));
            made++;
        end
        while (made < RANDOM_ITEMS) begin
            if (seg_left == 0) begin
                roll     = $urandom_range(0, 9);
                mode     = (roll < 4) ? 0 : (roll < 7) ? 1 : (roll < 9) ? 2 : 3;
                seg_left = $urandom_range(20, 150);
            end
            seg_left--;
            made++;
            roll = $urandom_range(0, 99);
            if (mode == 3) begin
                add_cmd(t_opcode'($urandom_range(0, 3)), $urandom_range(0, 255));
            end else begin
                case (mode)
                    0:       want_push = (roll < 85);
                    1:       want_push = (roll < 15);
                    default: want_push = (roll < 50);
                endcase
                if (!want_push) begin
                    add_cmd(OP_POP, $urandom_range(0, 255));
                end else if (msg_left > 1) begin
                    add_cmd(OP_MSG, $urandom_range(0, 255));
                    msg_left--;
                end else if (msg_left == 1) begin
                    add_cmd(OP_CRC, $urandom_range(0, 255));
                    msg_left = 0;
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 70) begin
                        // Message of 1..12 bytes followed by its CRC.
                        msg_left = $urandom_range(1, 12);
                        add_cmd(OP_MSG, $urandom_range(0, 255));
                    end else if (roll < 93) begin
                        add_cmd(OP_PUSH, $urandom_range(0, 255));
                    end else begin
                        add_cmd(OP_CRC, $urandom_range(0, 255));
                    end
                end
            end
        end
    endtask

    // Sender: offers the backlog in bursts of random length with random gaps.
    // A gap starts only after an item was taken, so it can land on any phase
    // of the block's item handling. Inputs change on falling edges.
    always @(negedge i_clk) begin
        t_fifo_cmd nxt;
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (gap_left > 0) begin
                cmd_if.valid <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() > 0) begin
                nxt = cmd_backlog.pop_front();
                cmd_if.opcode     <= nxt.op;
                cmd_if.byte_value <= nxt.value;
                cmd_if.valid      <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: switches at random between stall patterns. Once
    // enough results have come in, it holds ready low for a long stretch while
    // the sender keeps offering, so the block's result register stays full and
    // its input channel must stall.
    always @(negedge i_clk) begin
        if (hold_left == 0 && hold_at.size() > 0 && results_seen >= hold_at[0]) begin
            hold_left = HOLD_CYCLES;
            void'(hold_at.pop_front());
        end
        if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(16, 80);
        end
        phase_left--;
        stall_tick++;
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            case (stall_mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 1) == 1);
                2:       res_if.ready <= (stall_tick % 4 == 0);
                default: res_if.ready <= (stall_tick % 3 != 0);
            endcase
        end
    end

    // Monitor and scoreboard, on rising edges. A taken result is checked
    // against the oldest owed result before a newly taken item is predicted.
    // The watchdog counts edges with no handshake on either channel.
    always @(posedge i_clk) begin
        t_fifo_cmd    seen;
        t_fifo_status want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= cmd_if.valid && cmd_if.ready;
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (status_due.size() == 0) begin
                    $error("result item arrived with none expected");
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    compare_field("accepted",    8'(want.accepted), 8'(res_if.accepted));
                    compare_field("popped_byte", want.popped_byte,  res_if.popped_byte);
                    compare_field("is_full",     8'(want.is_full),  8'(res_if.is_full));
                    compare_field("is_empty",    8'(want.is_empty), 8'(res_if.is_empty));
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                seen.op    = cmd_if.opcode;
                seen.value = cmd_if.byte_value;
                status_due.push_back(fifo_step(seen));
            end
            if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Sequencing: plan all items, hold reset, then wait for
    // the backlog to be taken and every owed result to come back.
    initial begin
        cmd_if.valid      = 1'b0;
        cmd_if.opcode     = OP_PUSH;
        cmd_if.byte_value = 8'h00;
        res_if.ready      = 1'b0;
        shadow_wr         = '0;
        shadow_rd         = '0;
        shadow_crc        = CRC_INIT;

        plan_directed();
        plan_random_traffic();

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_backlog.size() > 0 || cmd_if.valid) @(posedge i_clk);
        while (status_due.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
